// ===== hw/rtl/h2r_pkg.sv =====
// Shared types and constants for the HSV to RGB pixel converter.
// Used by h2r_chan and hsv_to_rgb_pixel_unit; depends on nothing else.
package h2r_pkg;

   // Field widths.
   localparam int CHAN_W = 16;
   localparam int ANG_W  = 15;
   localparam int FRAC_W = 12;

   // Widths inside one channel lane.
   localparam int M_W    = 28;
   localparam int NUM_W  = 44;
   localparam int X_W    = 45;
   localparam int Y_W    = 37;
   localparam int A_W    = 21;
   localparam int C_W    = 22;
   localparam int W_W    = 21;
   localparam int PROD_W = 42;

   // Pipeline depths: lane stages, then the whole block.
   localparam int LANE_LAT = 7;
   localparam int LATENCY  = LANE_LAT + 3;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [ANG_W-1:0]  ang_type;
   typedef logic [FRAC_W-1:0] frac_type;
   typedef logic [M_W-1:0]    m_type;
   typedef logic [NUM_W-1:0]  num_type;
   typedef logic [X_W-1:0]    x_type;
   typedef logic [Y_W-1:0]    y_type;
   typedef logic [A_W-1:0]    a_type;
   typedef logic [C_W-1:0]    c_type;
   typedef logic [W_W-1:0]    w_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef logic signed [16:0] hue_ext_type;

   // Sextant of the color wheel.
   typedef enum logic [2:0] {
      SEC_RED_YELLOW   = 3'd0,
      SEC_YELLOW_GREEN = 3'd1,
      SEC_GREEN_CYAN   = 3'd2,
      SEC_CYAN_BLUE    = 3'd3,
      SEC_BLUE_MAGENTA = 3'd4,
      SEC_MAGENTA_RED  = 3'd5
   } sector_type;

   // Hue geometry: one turn is 23040 units, one sextant 3840.
   localparam hue_ext_type TURN_S  = 17'sd23040;
   localparam hue_ext_type TURN2_S = 17'sd46080;
   localparam ang_type     SEC_1   = 15'd3840;
   localparam ang_type     SEC_2   = 15'd7680;
   localparam ang_type     SEC_3   = 15'd11520;
   localparam ang_type     SEC_4   = 15'd15360;
   localparam ang_type     SEC_5   = 15'd19200;
   localparam frac_type    SECTOR_K = 12'd3840;

   // Common denominator 65535 * 3840, its half, and the reciprocal of 15
   // scaled by 2^24 and rounded up.
   localparam m_type    DEN      = 28'd251654400;
   localparam x_type    HALF_DEN = 45'd125827200;
   localparam prod_type RECIP15  = 42'd1118482;
   localparam logic [16:0] MOD_FULL = 17'd65535;

endpackage

// ===== hw/rtl/h2r_chan.sv =====
// One channel lane: round(v * (DEN - s * k) / DEN), half up, in seven stages.
// Depends on h2r_pkg for widths and constants.
module h2r_chan (
   input  logic              clock,
   input  h2r_pkg::frac_type k_i,
   input  h2r_pkg::chan_type s_i,
   input  h2r_pkg::chan_type v_i,
   output h2r_pkg::chan_type chan_o
);

   h2r_pkg::m_type    m_ff, m_in;
   h2r_pkg::m_type    e_ff, e_in;
   h2r_pkg::chan_type v1_ff, v2_ff;
   h2r_pkg::num_type  num_ff, num_in;
   h2r_pkg::y_type    y_ff, y_in;
   h2r_pkg::a_type    a_ff, a_in;
   h2r_pkg::c_type    c_ff, c_in;
   h2r_pkg::w_type    w_ff, w_in;
   h2r_pkg::prod_type prod_ff, prod_in;
   h2r_pkg::x_type    x_sum;
   logic [16:0]       fold_sum;

   // Numerator: product s * k, its complement to DEN, then times v.
   always_comb begin
      m_in   = h2r_pkg::m_type'(s_i) * h2r_pkg::m_type'(k_i);
      e_in   = h2r_pkg::DEN - m_ff;
      num_in = h2r_pkg::num_type'(v2_ff) * h2r_pkg::num_type'(e_ff);
   end

   // Add half the denominator and drop the factor of 256 in DEN.
   always_comb begin
      x_sum = h2r_pkg::x_type'(num_ff) + h2r_pkg::HALF_DEN;
      y_in  = x_sum[h2r_pkg::X_W-1:8];
   end

   // Divide by 65535: y = a * 65535 + (a + b), folded once more on a + b.
   always_comb begin
      a_in     = y_ff[h2r_pkg::Y_W-1:16];
      c_in     = h2r_pkg::c_type'(y_ff[h2r_pkg::Y_W-1:16])
                 + h2r_pkg::c_type'(y_ff[15:0]);
      fold_sum = {1'b0, c_ff[15:0]} + 17'(c_ff[h2r_pkg::C_W-1:16]);
      w_in     = a_ff + h2r_pkg::w_type'(c_ff[h2r_pkg::C_W-1:16])
                 + h2r_pkg::w_type'(fold_sum >= h2r_pkg::MOD_FULL);
   end

   // Divide by 15 through the scaled reciprocal; exact for this range.
   always_comb begin
      prod_in = h2r_pkg::prod_type'(w_ff) * h2r_pkg::RECIP15;
   end

   // Lane registers; payload only, so no reset.
   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      v1_ff   <= v_i;
      e_ff    <= e_in;
      v2_ff   <= v1_ff;
      num_ff  <= num_in;
      y_ff    <= y_in;
      a_ff    <= a_in;
      c_ff    <= c_in;
      w_ff    <= w_in;
      prod_ff <= prod_in;
   end

   assign chan_o = prod_ff[39:24];

endmodule

// ===== hw/rtl/hsv_to_rgb_pixel_unit.sv =====
// Top level of the HSV to RGB pixel converter.
// Depends on h2r_pkg and instantiates three h2r_chan lanes.
//
// Usage:
// A pixel is offered on req_hue, req_saturation and req_brightness with
// start high; the transfer happens at a rising edge where start is high
// and busy is low. The pipeline never stalls, so busy stays low and a
// new pixel may enter on every clock cycle.
// Each result appears on rsp_red, rsp_green and rsp_blue for exactly one
// cycle with rsp_valid high; the transfer edge loads the hue wrap stage,
// and the sextant split, seven lane stages and the output register follow.
// Throughput is one pixel per cycle, set by the fully pipelined lanes.
// The receiver cannot stall; results are taken as they appear.
// A synchronous reset clears every valid bit, so pixels in flight are
// dropped and no result appears until new pixels are sent.
// Zero saturation and zero brightness need no special path: the lanes
// return brightness and zero for them.
module hsv_to_rgb_pixel_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic signed [15:0] req_hue,
   input  h2r_pkg::chan_type req_saturation,
   input  h2r_pkg::chan_type req_brightness,
   output logic              rsp_valid,
   output h2r_pkg::chan_type rsp_red,
   output h2r_pkg::chan_type rsp_green,
   output h2r_pkg::chan_type rsp_blue
);

   logic                  accept;
   h2r_pkg::hue_ext_type  hue_ext;
   h2r_pkg::hue_ext_type  hue_wrap;

   logic                  s1_valid_ff, s1_valid_in;
   h2r_pkg::ang_type      rem_ff, rem_in;
   h2r_pkg::chan_type     s1_sat_ff, s1_val_ff;

   logic                  s2_valid_ff;
   h2r_pkg::sector_type   s2_sector_ff, s2_sector_in;
   h2r_pkg::frac_type     s2_frac_ff, s2_frac_in;
   h2r_pkg::ang_type      sector_base;
   h2r_pkg::ang_type      frac_diff;
   h2r_pkg::chan_type     s2_sat_ff, s2_val_ff;

   logic                  valid_pipe_ff [h2r_pkg::LANE_LAT];
   h2r_pkg::sector_type   sector_pipe_ff[h2r_pkg::LANE_LAT];
   h2r_pkg::chan_type     val_pipe_ff   [h2r_pkg::LANE_LAT];

   h2r_pkg::frac_type     k_q, k_t;
   h2r_pkg::chan_type     p_chan, q_chan, t_chan;

   logic                  rsp_valid_ff;
   h2r_pkg::chan_type     red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   h2r_pkg::chan_type     val_last;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Wrap the hue into one turn with one add from a set of constants.
   always_comb begin
      hue_ext = h2r_pkg::hue_ext_type'(req_hue);
      if (hue_ext < -h2r_pkg::TURN_S) begin
         hue_wrap = hue_ext + h2r_pkg::TURN2_S;
      end else if (hue_ext < 17'sd0) begin
         hue_wrap = hue_ext + h2r_pkg::TURN_S;
      end else if (hue_ext >= h2r_pkg::TURN_S) begin
         hue_wrap = hue_ext - h2r_pkg::TURN_S;
      end else begin
         hue_wrap = hue_ext;
      end
      rem_in      = hue_wrap[h2r_pkg::ANG_W-1:0];
      s1_valid_in = accept;
   end

   // Split the wrapped hue into sextant and offset within it.
   always_comb begin
      if (rem_ff >= h2r_pkg::SEC_5) begin
         s2_sector_in = h2r_pkg::SEC_MAGENTA_RED;
         sector_base  = h2r_pkg::SEC_5;
      end else if (rem_ff >= h2r_pkg::SEC_4) begin
         s2_sector_in = h2r_pkg::SEC_BLUE_MAGENTA;
         sector_base  = h2r_pkg::SEC_4;
      end else if (rem_ff >= h2r_pkg::SEC_3) begin
         s2_sector_in = h2r_pkg::SEC_CYAN_BLUE;
         sector_base  = h2r_pkg::SEC_3;
      end else if (rem_ff >= h2r_pkg::SEC_2) begin
         s2_sector_in = h2r_pkg::SEC_GREEN_CYAN;
         sector_base  = h2r_pkg::SEC_2;
      end else if (rem_ff >= h2r_pkg::SEC_1) begin
         s2_sector_in = h2r_pkg::SEC_YELLOW_GREEN;
         sector_base  = h2r_pkg::SEC_1;
      end else begin
         s2_sector_in = h2r_pkg::SEC_RED_YELLOW;
         sector_base  = '0;
      end
      frac_diff  = rem_ff - sector_base;
      s2_frac_in = frac_diff[h2r_pkg::FRAC_W-1:0];
   end

   // Front stages: valid bits reset, payload does not.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      s1_sat_ff    <= req_saturation;
      s1_val_ff    <= req_brightness;
      s2_sector_ff <= s2_sector_in;
      s2_frac_ff   <= s2_frac_in;
      s2_sat_ff    <= s1_sat_ff;
      s2_val_ff    <= s1_val_ff;
   end

   // The three lanes: p uses the full sextant, q the offset, t its rest.
   assign k_q = s2_frac_ff;
   assign k_t = h2r_pkg::SECTOR_K - s2_frac_ff;

   h2r_chan u_chan_p (
      .clock  (clock),
      .k_i    (h2r_pkg::SECTOR_K),
      .s_i    (s2_sat_ff),
      .v_i    (s2_val_ff),
      .chan_o (p_chan)
   );

   h2r_chan u_chan_q (
      .clock  (clock),
      .k_i    (k_q),
      .s_i    (s2_sat_ff),
      .v_i    (s2_val_ff),
      .chan_o (q_chan)
   );

   h2r_chan u_chan_t (
      .clock  (clock),
      .k_i    (k_t),
      .s_i    (s2_sat_ff),
      .v_i    (s2_val_ff),
      .chan_o (t_chan)
   );

   // Side pipeline that keeps valid, sextant and value beside the lanes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < h2r_pkg::LANE_LAT; i++) begin
            valid_pipe_ff[i] <= 1'b0;
         end
      end else begin
         valid_pipe_ff[0] <= s2_valid_ff;
         for (int i = 1; i < h2r_pkg::LANE_LAT; i++) begin
            valid_pipe_ff[i] <= valid_pipe_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      sector_pipe_ff[0] <= s2_sector_ff;
      val_pipe_ff[0]    <= s2_val_ff;
      for (int i = 1; i < h2r_pkg::LANE_LAT; i++) begin
         sector_pipe_ff[i] <= sector_pipe_ff[i-1];
         val_pipe_ff[i]    <= val_pipe_ff[i-1];
      end
   end

   // Route value, p, q and t to the channels by sextant.
   always_comb begin
      val_last = val_pipe_ff[h2r_pkg::LANE_LAT-1];
      case (sector_pipe_ff[h2r_pkg::LANE_LAT-1])
         h2r_pkg::SEC_RED_YELLOW: begin
            red_in = val_last; green_in = t_chan;   blue_in = p_chan;
         end
         h2r_pkg::SEC_YELLOW_GREEN: begin
            red_in = q_chan;   green_in = val_last; blue_in = p_chan;
         end
         h2r_pkg::SEC_GREEN_CYAN: begin
            red_in = p_chan;   green_in = val_last; blue_in = t_chan;
         end
         h2r_pkg::SEC_CYAN_BLUE: begin
            red_in = p_chan;   green_in = q_chan;   blue_in = val_last;
         end
         h2r_pkg::SEC_BLUE_MAGENTA: begin
            red_in = t_chan;   green_in = p_chan;   blue_in = val_last;
         end
         default: begin
            red_in = val_last; green_in = p_chan;   blue_in = q_chan;
         end
      endcase
   end

   // Output register and strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_pipe_ff[h2r_pkg::LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // A result strobe always traces back to a transfer a full latency ago.
   a_strobe_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, h2r_pkg::LATENCY))
      else $error("result strobe without a matching input transfer");

   // One channel carries the brightness of the pixel that produced it.
   a_value_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_red   == $past(req_brightness, h2r_pkg::LATENCY)) ||
         (rsp_green == $past(req_brightness, h2r_pkg::LATENCY)) ||
         (rsp_blue  == $past(req_brightness, h2r_pkg::LATENCY)))
      else $error("no channel equals the pixel brightness");

   // No channel exceeds the brightness.
   a_channels_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_red   <= $past(req_brightness, h2r_pkg::LATENCY)) &&
         (rsp_green <= $past(req_brightness, h2r_pkg::LATENCY)) &&
         (rsp_blue  <= $past(req_brightness, h2r_pkg::LATENCY)))
      else $error("channel above pixel brightness");

   // Zero saturation gives a grey pixel.
   a_grey_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ($past(req_saturation, h2r_pkg::LATENCY) == '0) |->
         (rsp_red == rsp_green) && (rsp_green == rsp_blue))
      else $error("unsaturated pixel is not grey");

endmodule

// ===== tb/hsv_to_rgb_pixel_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the HSV to RGB pixel converter.
// Depends on h2r_pkg and hsv_to_rgb_pixel_unit; predicts every pixel in-line.
module hsv_to_rgb_pixel_unit_tb;

   localparam int CLK_HALF = 4;
   localparam int RESET_CYCLES = 10;
   localparam int RANDOM_PIXELS = 530;
   localparam int IDLE_PERCENT = 7;
   localparam int REPORT_LIMIT = 10;

   // Hue geometry and channel scale used by the predictor.
   localparam int HUE_TURN = 23040;
   localparam int HUE_SEXTANT = 3840;
   localparam longint unsigned CHAN_FULL = 65535;
   localparam longint unsigned CHAN_DENOM = 65535 * 3840;

   typedef struct packed {
      h2r_pkg::chan_type red;
      h2r_pkg::chan_type green;
      h2r_pkg::chan_type blue;
   } rgb_pixel_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [15:0] req_hue;
   h2r_pkg::chan_type req_saturation;
   h2r_pkg::chan_type req_brightness;
   logic rsp_valid;
   h2r_pkg::chan_type rsp_red;
   h2r_pkg::chan_type rsp_green;
   h2r_pkg::chan_type rsp_blue;

   rgb_pixel_type expected_pixels[$];
   int fail_count = 0;
   int pixels_sent = 0;
   int pixels_checked = 0;
   int random_sent = 0;

   hsv_to_rgb_pixel_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_hue(req_hue),
      .req_saturation(req_saturation),
      .req_brightness(req_brightness),
      .rsp_valid(rsp_valid),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue)
   );

   // Free-running clock, 8 ns period.
   always begin
      clock = 1'b0;
      #(CLK_HALF);
      clock = 1'b1;
      #(CLK_HALF);
   end

   // Rounds num/den half up.
   function automatic longint unsigned round_ratio(longint unsigned num,
                                                   longint unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   // Expected RGB pixel for one HSV input, exact rational arithmetic.
   function automatic rgb_pixel_type hsv_pixel_to_rgb(logic signed [15:0] hue,
                                                      h2r_pkg::chan_type sat,
                                                      h2r_pkg::chan_type bri);
      int wrapped;
      longint unsigned frac;
      longint unsigned s;
      longint unsigned v;
      longint unsigned p;
      longint unsigned q;
      longint unsigned t;
      h2r_pkg::sector_type sextant;
      rgb_pixel_type px;
      s = sat;
      v = bri;
      if (bri == 0) begin
         px = '0;
      end else if (sat == 0) begin
         px.red = bri;
         px.green = bri;
         px.blue = bri;
      end else begin
         // Wrap the signed hue into one turn, then split it into sextant and offset.
         wrapped = (int'(hue) + 3 * HUE_TURN) % HUE_TURN;
         sextant = h2r_pkg::sector_type'(wrapped / HUE_SEXTANT);
         frac = wrapped % HUE_SEXTANT;
         p = round_ratio(v * (CHAN_FULL - s), CHAN_FULL);
         q = round_ratio(v * (CHAN_DENOM - s * frac), CHAN_DENOM);
         t = round_ratio(v * (CHAN_DENOM - s * (HUE_SEXTANT - frac)), CHAN_DENOM);
         case (sextant)
            h2r_pkg::SEC_RED_YELLOW: begin
               px = {bri, h2r_pkg::chan_type'(t), h2r_pkg::chan_type'(p)};
            end
            h2r_pkg::SEC_YELLOW_GREEN: begin
               px = {h2r_pkg::chan_type'(q), bri, h2r_pkg::chan_type'(p)};
            end
            h2r_pkg::SEC_GREEN_CYAN: begin
               px = {h2r_pkg::chan_type'(p), bri, h2r_pkg::chan_type'(t)};
            end
            h2r_pkg::SEC_CYAN_BLUE: begin
               px = {h2r_pkg::chan_type'(p), h2r_pkg::chan_type'(q), bri};
            end
            h2r_pkg::SEC_BLUE_MAGENTA: begin
               px = {h2r_pkg::chan_type'(t), h2r_pkg::chan_type'(p), bri};
            end
            default: begin
               px = {bri, h2r_pkg::chan_type'(p), h2r_pkg::chan_type'(q)};
            end
         endcase
      end
      return px;
   endfunction

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%s", msg);
      end
   endtask

   // Appends one expectation at the tail of the queue.
   task automatic queue_expected(input rgb_pixel_type px);
      expected_pixels.insert(expected_pixels.size(), px);
   endtask

   // Checks each result against the oldest expectation, then records a new
   // expectation for every input transfer seen at this edge.
   always @(posedge clock) begin : result_check
      rgb_pixel_type want;
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            report_failure($sformatf("ERROR: unexpected pixel r=%0d g=%0d b=%0d",
                                     rsp_red, rsp_green, rsp_blue));
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_red !== want.red || rsp_green !== want.green ||
                rsp_blue !== want.blue) begin
               report_failure($sformatf(
                  "ERROR: pixel %0d expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                  pixels_checked, want.red, want.green, want.blue,
                  rsp_red, rsp_green, rsp_blue));
            end
         end
      end
      if (!reset && start && !busy) begin
         queue_expected(hsv_pixel_to_rgb(req_hue, req_saturation, req_brightness));
         pixels_sent++;
      end
   end

   // Offers one pixel and returns once its transfer has happened. Start is
   // left high so that the next pixel can follow without a gap.
   task automatic send_pixel(input logic signed [15:0] hue, input h2r_pkg::chan_type sat,
                             input h2r_pkg::chan_type bri);
      @(negedge clock);
      req_hue <= hue;
      req_saturation <= sat;
      req_brightness <= bri;
      start <= 1'b1;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   // Sender holds start low for the requested cycles, with random data on the inactive bus.
   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
         req_hue <= 16'($urandom);
         req_saturation <= 16'($urandom);
         req_brightness <= 16'($urandom);
      end
   endtask

   // Sender stops until every expected pixel has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (expected_pixels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Black, grey and the hue extremes, including wrap in both directions.
   task automatic test_special_cases();
      send_pixel(16'sd0, 16'd0, 16'd0);
      send_pixel(16'sh8000, 16'hFFFF, 16'd0);
      send_pixel(16'sd32767, 16'd0, 16'hFFFF);
      send_pixel(16'sd1234, 16'd0, 16'd1);
      send_pixel(16'sh8000, 16'hFFFF, 16'hFFFF);
      send_pixel(16'sd32767, 16'hFFFF, 16'hFFFF);
      send_pixel(-16'sd1, 16'hFFFF, 16'hFFFF);
      send_pixel(16'sd23040, 16'h8000, 16'hFFFF);
      send_pixel(-16'sd23040, 16'd1, 16'd1);
      send_pixel(16'sd23039, 16'hFFFF, 16'h7FFF);
   endtask

   // First and last hue of every sextant, with random nonzero S and V.
   task automatic test_sextant_edges();
      for (int k = 0; k < 6; k++) begin
         send_pixel(16'(k * HUE_SEXTANT), 16'($urandom_range(65535, 1)),
                    16'($urandom_range(65535, 1)));
         send_pixel(16'(k * HUE_SEXTANT + HUE_SEXTANT - 1), 16'($urandom_range(65535, 1)),
                    16'($urandom_range(65535, 1)));
      end
   endtask

   // Random pixels with occasional idle cycles, a burst with none, and one
   // full drain half way through.
   task automatic test_random_pixels();
      logic signed [15:0] hue;
      h2r_pkg::chan_type sat;
      h2r_pkg::chan_type bri;
      int pick;
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i == RANDOM_PIXELS / 2) begin
            wait_for_drain();
         end
         // Pixels 300 to 449 go back to back.
         if ((i < 300 || i >= 450) && $urandom_range(99) < IDLE_PERCENT) begin
            hold_off(1);
         end
         hue = 16'($urandom);
         sat = 16'($urandom);
         bri = 16'($urandom);
         pick = $urandom_range(99);
         if (pick < 5) begin
            bri = '0;
         end else if (pick < 10) begin
            sat = '0;
         end else if (pick < 15) begin
            sat = '1;
         end else if (pick < 20) begin
            bri = '1;
         end else if (pick < 25) begin
            hue = 16'($urandom_range(5) * HUE_SEXTANT) + 16'($urandom_range(2)) - 16'sd1;
         end
         send_pixel(hue, sat, bri);
         random_sent++;
      end
   endtask

   // Run-time limit.
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   // Test sequence.
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_hue = '0;
      req_saturation = '0;
      req_brightness = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_special_cases();
      test_sextant_edges();
      test_random_pixels();

      // Let the pipeline empty, then wait longer than the block latency for stray results.
      wait_for_drain();
      repeat (h2r_pkg::LATENCY + 4) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         report_failure($sformatf("ERROR: %0d pixels never came back", expected_pixels.size()));
      end

      $display("Summary: %0d pixels in, %0d checked (%0d random); black, grey, wrapped hues,",
               pixels_sent, pixels_checked, random_sent);
      $display("Summary: all sextant edges, idle gaps and one full drain; %0d failures.",
               fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
